// File: src/cmtdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmtdr_pkg
// Shared constants, types and codes of the clipmap toroidal dirty-rect unit.
// ----------------------------------------------------------------------------
package cmtdr_pkg;

	localparam int MAX_LEVELS  = 16;
	localparam int COORD_BITS  = 12;
	localparam int ORIGIN_W    = 24;
	localparam int LVL_W       = 4;
	localparam int CNT_W       = 5;
	localparam int SH_W        = $clog2(MAX_LEVELS);
	localparam int MC_W        = $clog2(COORD_BITS);
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = COORD_BITS;
	localparam int RECTS       = 4;
	localparam int RSEL_W      = $clog2(RECTS);
	localparam int SIZE_MIN    = 3;
	localparam int SIZE_RESET  = 255;
	localparam int COUNT_RESET = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEVEL_SIZE,
		REG_LEVEL_COUNT
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MOD,
		ST_CALC,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic check;
		logic mod_step;
		logic calc;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic mod_need;
		logic mod_last;
		logic rect_any;
		logic rect_last;
		logic out_free;
	} status_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x0;
		logic [COORD_BITS-1:0] y0;
		logic [COORD_BITS-1:0] x1;
		logic [COORD_BITS-1:0] y1;
	} rect_t;

endpackage

// File: src/cmtdr_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmtdr channel interfaces
// Level update requests, dirty rectangle results and register writes.
// ----------------------------------------------------------------------------
interface cmtdr_req_if;
	import cmtdr_pkg::*;
	logic                       valid;
	logic                       ready;
	logic [LVL_W-1:0]           level_index;
	logic signed [ORIGIN_W-1:0] new_origin_x;
	logic signed [ORIGIN_W-1:0] new_origin_y;

	modport source (output valid, level_index, new_origin_x, new_origin_y, input ready);
	modport sink (input valid, level_index, new_origin_x, new_origin_y, output ready);
endinterface

interface cmtdr_rect_if;
	import cmtdr_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] rect_x_start;
	logic [COORD_BITS-1:0] rect_y_start;
	logic [COORD_BITS-1:0] rect_x_end;
	logic [COORD_BITS-1:0] rect_y_end;
	logic [COORD_BITS-1:0] block_origin_x;
	logic [COORD_BITS-1:0] block_origin_y;
	logic                  full_update;
	logic                  last_rect;

	modport source (output valid, rect_x_start, rect_y_start, rect_x_end, rect_y_end,
		block_origin_x, block_origin_y, full_update, last_rect, input ready);
	modport sink (input valid, rect_x_start, rect_y_start, rect_x_end, rect_y_end,
		block_origin_x, block_origin_y, full_update, last_rect, output ready);
endinterface

interface cmtdr_cfg_if;
	import cmtdr_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: src/cmtdr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmtdr_ctrl
// Sequencer: check, optional origin reduction, strip calculation, emission.
// ----------------------------------------------------------------------------
module cmtdr_ctrl import cmtdr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) state_nxt = ST_CHECK;
			end
			ST_CHECK: begin
				if (status.skip) state_nxt = ST_IDLE;
				else if (status.mod_need) state_nxt = ST_MOD;
				else state_nxt = ST_CALC;
			end
			ST_MOD: begin
				if (status.mod_last) state_nxt = ST_CALC;
			end
			ST_CALC: begin
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (!status.rect_any) state_nxt = ST_IDLE;
				else if (status.out_free && status.rect_last) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			ST_CHECK: cmd.check = 1'b1;
			ST_MOD:   cmd.mod_step = 1'b1;
			ST_CALC:  cmd.calc = 1'b1;
			ST_EMIT:  cmd.emit = status.rect_any && status.out_free;
			default: begin
				cmd       = '0;
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

// File: src/cmtdr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmtdr_dp
// Level state, config registers, origin reduction, strip math, output stage.
// ----------------------------------------------------------------------------
module cmtdr_dp import cmtdr_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [LVL_W-1:0]           level_index,
	input  logic signed [ORIGIN_W-1:0] new_origin_x,
	input  logic signed [ORIGIN_W-1:0] new_origin_y,
	input  cmd_t                       cmd,
	output status_t                    status,
	cmtdr_cfg_if.sink                  cfg,
	cmtdr_rect_if.source               rect
);

	localparam int CW = COORD_BITS;
	localparam int OW = ORIGIN_W;
	localparam int DW = ORIGIN_W + 1;

	typedef struct packed {
		logic          nz;
		logic          split;
		logic [CW-1:0] org;
		logic [CW-1:0] a0;
		logic [CW-1:0] lo_end;
		logic [CW-1:0] hi_end;
	} axis_t;

	function automatic axis_t axis_step(input logic [CW-1:0] o, input logic [CW-1:0] m,
		input logic n, input logic [CW-1:0] sz);
		axis_t      r;
		logic [CW:0] szx;
		logic [CW:0] s;
		logic [CW:0] so;
		logic [CW:0] d;
		logic [CW:0] a1;
		logic [CW:0] hi;
		szx = {1'b0, sz};
		s   = {1'b0, o} + {1'b0, m};
		so  = s - szx;
		d   = {1'b0, o} - {1'b0, m};
		if (n) begin
			r.org = d[CW] ? (d[CW-1:0] + sz) : d[CW-1:0];
			r.a0  = r.org;
			a1    = {1'b0, r.org} + {1'b0, m};
		end else begin
			r.org = (s >= szx) ? so[CW-1:0] : s[CW-1:0];
			r.a0  = o;
			a1    = s;
		end
		hi       = a1 - szx;
		r.nz     = (m != '0);
		r.split  = (a1 > szx);
		r.lo_end = r.split ? sz : a1[CW-1:0];
		r.hi_end = hi[CW-1:0];
		return r;
	endfunction

	// config
	logic [CW-1:0]    size_q;
	logic [CNT_W-1:0] count_q;
	logic [CW-1:0]    size_eff;
	logic [CNT_W-1:0] cnt_eff;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= CW'(SIZE_RESET);
			count_q <= CNT_W'(COUNT_RESET);
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_LEVEL_SIZE:  size_q <= cfg.data[CW-1:0];
				REG_LEVEL_COUNT: count_q <= cfg.data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		size_eff = (size_q < CW'(SIZE_MIN)) ? CW'(SIZE_MIN) : size_q;
		if (count_q == '0) cnt_eff = CNT_W'(1);
		else if (count_q > CNT_W'(MAX_LEVELS)) cnt_eff = CNT_W'(MAX_LEVELS);
		else cnt_eff = count_q;
	end

	// per-level state
	logic [OW-1:0]         sox_mem [MAX_LEVELS];
	logic [OW-1:0]         soy_mem [MAX_LEVELS];
	logic [CW-1:0]         wx_mem  [MAX_LEVELS];
	logic [CW-1:0]         wy_mem  [MAX_LEVELS];
	logic [MAX_LEVELS-1:0] dirty_q;

	// request registers
	logic [LVL_W-1:0] lvl_q;
	logic [OW-1:0]    nx_q;
	logic [OW-1:0]    ny_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lvl_q <= level_index;
			nx_q  <= new_origin_x;
			ny_q  <= new_origin_y;
		end
	end

	// check
	logic [OW-1:0]    sox;
	logic [OW-1:0]    soy;
	logic [CW-1:0]    wx;
	logic [CW-1:0]    wy;
	logic             dirty;
	logic [DW-1:0]    dx;
	logic [DW-1:0]    dy;
	logic [DW-1:0]    absdx;
	logic [DW-1:0]    absdy;
	logic             full;
	logic             skip;
	logic             mod_need;
	logic [CNT_W-1:0] sh_full;

	always_comb begin
		sox      = sox_mem[lvl_q];
		soy      = soy_mem[lvl_q];
		wx       = wx_mem[lvl_q];
		wy       = wy_mem[lvl_q];
		dirty    = dirty_q[lvl_q];
		dx       = {nx_q[OW-1], nx_q} - {sox[OW-1], sox};
		dy       = {ny_q[OW-1], ny_q} - {soy[OW-1], soy};
		absdx    = dx[DW-1] ? (~dx + DW'(1)) : dx;
		absdy    = dy[DW-1] ? (~dy + DW'(1)) : dy;
		full     = dirty || (absdx >= DW'(size_eff)) || (absdy >= DW'(size_eff));
		skip     = ({1'b0, lvl_q} >= cnt_eff) || (!dirty && dx == '0 && dy == '0);
		mod_need = !full && ((wx >= size_eff) || (wy >= size_eff));
		sh_full  = cnt_eff - CNT_W'(1) - {1'b0, lvl_q};
	end

	logic            full_q;
	logic [CW-1:0]   magx_q;
	logic [CW-1:0]   magy_q;
	logic            negx_q;
	logic            negy_q;
	logic [SH_W-1:0] sh_q;

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			full_q <= full;
			magx_q <= absdx[CW-1:0];
			magy_q <= absdy[CW-1:0];
			negx_q <= dx[DW-1];
			negy_q <= dy[DW-1];
			sh_q   <= sh_full[SH_W-1:0];
		end
	end

	// origin reduction, one bit per cycle
	logic [CW-1:0]   remx_q;
	logic [CW-1:0]   remy_q;
	logic [CW-1:0]   shx_q;
	logic [CW-1:0]   shy_q;
	logic [MC_W-1:0] mcnt_q;
	logic [CW:0]     rx2;
	logic [CW:0]     ry2;
	logic [CW:0]     rxn;
	logic [CW:0]     ryn;

	always_comb begin
		rx2 = {remx_q, shx_q[CW-1]};
		ry2 = {remy_q, shy_q[CW-1]};
		rxn = (rx2 >= {1'b0, size_eff}) ? (rx2 - {1'b0, size_eff}) : rx2;
		ryn = (ry2 >= {1'b0, size_eff}) ? (ry2 - {1'b0, size_eff}) : ry2;
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			mcnt_q <= '0;
			shx_q  <= wx;
			shy_q  <= wy;
			remx_q <= mod_need ? '0 : wx;
			remy_q <= mod_need ? '0 : wy;
		end else if (cmd.mod_step) begin
			mcnt_q <= mcnt_q + MC_W'(1);
			shx_q  <= shx_q << 1;
			shy_q  <= shy_q << 1;
			remx_q <= rxn[CW-1:0];
			remy_q <= ryn[CW-1:0];
		end
	end

	// strips
	logic [CW-1:0] bmx;
	logic [CW-1:0] bmy;
	axis_t         ax;
	axis_t         ay;

	always_comb begin
		bmx = magx_q >> sh_q;
		bmy = magy_q >> sh_q;
		ax  = axis_step(remx_q, bmx, negx_q, size_eff);
		ay  = axis_step(remy_q, bmy, negy_q, size_eff);
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			sox_mem[lvl_q] <= nx_q;
			soy_mem[lvl_q] <= ny_q;
			wx_mem[lvl_q]  <= full_q ? '0 : ax.org;
			wy_mem[lvl_q]  <= full_q ? '0 : ay.org;
		end
	end

	rect_t           rects_q [RECTS];
	logic [RECTS-1:0] mask_q;
	logic [CW-1:0]   box_q;
	logic [CW-1:0]   boy_q;
	logic [RSEL_W-1:0] sel;

	always_comb begin
		sel = '0;
		for (int i = RECTS - 1; i >= 0; i--) begin
			if (mask_q[i]) sel = RSEL_W'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			if (full_q) begin
				rects_q[0] <= '{x0: '0, y0: '0, x1: size_eff, y1: size_eff};
				box_q      <= '0;
				boy_q      <= '0;
			end else begin
				rects_q[0] <= '{x0: ax.a0, y0: '0, x1: ax.lo_end, y1: size_eff};
				rects_q[1] <= '{x0: '0, y0: '0, x1: ax.hi_end, y1: size_eff};
				rects_q[2] <= '{x0: '0, y0: ay.a0, x1: size_eff, y1: ay.lo_end};
				rects_q[3] <= '{x0: '0, y0: '0, x1: size_eff, y1: ay.hi_end};
				box_q      <= ax.org;
				boy_q      <= ay.org;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= '1;
			mask_q  <= '0;
		end else begin
			if (cmd.calc) begin
				dirty_q[lvl_q] <= 1'b0;
				if (full_q) mask_q <= RECTS'(1);
				else mask_q <= {ay.nz & ay.split, ay.nz, ax.nz & ax.split, ax.nz};
			end else if (cmd.emit) begin
				mask_q[sel] <= 1'b0;
			end
		end
	end

	// output stage
	logic          out_valid_q;
	rect_t         out_rect_q;
	logic [CW-1:0] out_box_q;
	logic [CW-1:0] out_boy_q;
	logic          out_full_q;
	logic          out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rect.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_rect_q <= rects_q[sel];
			out_box_q  <= box_q;
			out_boy_q  <= boy_q;
			out_full_q <= full_q;
			out_last_q <= $onehot(mask_q);
		end
	end

	assign rect.valid          = out_valid_q;
	assign rect.rect_x_start   = out_rect_q.x0;
	assign rect.rect_y_start   = out_rect_q.y0;
	assign rect.rect_x_end     = out_rect_q.x1;
	assign rect.rect_y_end     = out_rect_q.y1;
	assign rect.block_origin_x = out_box_q;
	assign rect.block_origin_y = out_boy_q;
	assign rect.full_update    = out_full_q;
	assign rect.last_rect      = out_last_q;

	always_comb begin
		status.skip      = skip;
		status.mod_need  = mod_need;
		status.mod_last  = (mcnt_q == MC_W'(COORD_BITS - 1));
		status.rect_any  = |mask_q;
		status.rect_last = $onehot(mask_q);
		status.out_free  = !out_valid_q || rect.ready;
	end

	a_rect_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_rect_q.x0 < out_rect_q.x1) && (out_rect_q.y0 < out_rect_q.y1))
		else $error("empty rectangle on output");

	a_full_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_full_q |-> out_last_q)
		else $error("full refresh not marked last");

	a_rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mod_step |-> (remx_q < size_eff) && (remy_q < size_eff))
		else $error("origin reduction out of range");

	a_origin_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_box_q < size_eff) && (out_boy_q < size_eff))
		else $error("block origin not below level size");

endmodule

// File: src/clipmap_toroidal_dirty_rects_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipmap_toroidal_dirty_rects_unit
// Per-level toroidal origin tracking and dirty rectangle generation.
// ----------------------------------------------------------------------------
// One request is handled at a time. An ignored request (level out of range, or
// no move on a level that is not dirty) is only accepted and checked. Otherwise
// the sequencer accepts it, checks the stored level state, does the strip math
// and emits each rectangle in turn (none when a sub-spacing move emits nothing,
// up to four), holding emission while the output register is still occupied.
// When level_size was changed, a stored block origin is not below it and the
// move is no full refresh, a shared bit-serial remainder unit reduces that
// origin before the strip math. The last rectangle waits in the output
// register while the next request is accepted.
module clipmap_toroidal_dirty_rects_unit import cmtdr_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	cmtdr_req_if.sink    req,
	cmtdr_rect_if.source rect,
	cmtdr_cfg_if.sink    cfg
);

	cmd_t    cmd;
	status_t status;

	cmtdr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	cmtdr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.level_index  (req.level_index),
		.new_origin_x (req.new_origin_x),
		.new_origin_y (req.new_origin_y),
		.cmd          (cmd),
		.status       (status),
		.cfg          (cfg),
		.rect         (rect)
	);

endmodule

// File: tb/sv/tb_clipmap_toroidal_dirty_rects_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clipmap_toroidal_dirty_rects_unit
// Self-checking bench for the clipmap toroidal dirty-rect unit. A clocked
// driver sends level update requests from a queue in random bursts. A local
// copy of the level state predicts the dirty rectangles each accepted request
// produces. A clocked monitor stalls the result channel on a per-phase
// pattern and checks every rectangle field by field. Register writes happen
// between phases, once the unit is idle: defaults, both extremes, clamped and
// masked values, and random settings.
// ----------------------------------------------------------------------------
module tb_clipmap_toroidal_dirty_rects_unit;
	import cmtdr_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 30;

	typedef struct {
		logic [LVL_W-1:0]           lvl;
		logic signed [ORIGIN_W-1:0] x;
		logic signed [ORIGIN_W-1:0] y;
	} level_move_t;

	typedef struct {
		logic [COORD_BITS-1:0] x_start;
		logic [COORD_BITS-1:0] y_start;
		logic [COORD_BITS-1:0] x_end;
		logic [COORD_BITS-1:0] y_end;
		logic [COORD_BITS-1:0] origin_x;
		logic [COORD_BITS-1:0] origin_y;
		logic                  full;
		logic                  last;
	} dirty_rect_t;

	logic clk;
	logic arst_n;

	cmtdr_req_if  req_ch ();
	cmtdr_rect_if rect_ch ();
	cmtdr_cfg_if  cfg_ch ();

	clipmap_toroidal_dirty_rects_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rect   (rect_ch),
		.cfg    (cfg_ch)
	);

	// register copy and per-level state
	logic [COORD_BITS-1:0]      level_size_reg;
	logic [CNT_W-1:0]           level_count_reg;
	logic signed [ORIGIN_W-1:0] origin_x [MAX_LEVELS];
	logic signed [ORIGIN_W-1:0] origin_y [MAX_LEVELS];
	logic [COORD_BITS-1:0]      wrap_x [MAX_LEVELS];
	logic [COORD_BITS-1:0]      wrap_y [MAX_LEVELS];
	bit                         level_dirty [MAX_LEVELS];

	// last origin queued per level
	logic signed [ORIGIN_W-1:0] sent_x [MAX_LEVELS];
	logic signed [ORIGIN_W-1:0] sent_y [MAX_LEVELS];

	level_move_t moves_pending [$];
	dirty_rect_t rects_due [$];
	dirty_rect_t rect_batch [$];

	int          mismatches;
	int          burst_left;
	int          gap_left;
	int          idle_cycles;
	int          ready_phase;
	bit          sender_quiet;
	bit          no_stall;
	logic [15:0] stall_pattern;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_count();
		int c;
		c = int'(level_count_reg);
		if (c < 1) c = 1;
		if (c > MAX_LEVELS) c = MAX_LEVELS;
		return c;
	endfunction

	function automatic int eff_size();
		int s;
		s = int'(level_size_reg);
		if (s < SIZE_MIN) s = SIZE_MIN;
		return s;
	endfunction

	function automatic int wrap_to(int v, int sz);
		int r;
		r = v % sz;
		if (r < 0) r += sz;
		return r;
	endfunction

	task automatic add_rect(int x0, int y0, int x1, int y1, int bx, int by, bit full);
		dirty_rect_t r;
		r.x_start  = x0[COORD_BITS-1:0];
		r.y_start  = y0[COORD_BITS-1:0];
		r.x_end    = x1[COORD_BITS-1:0];
		r.y_end    = y1[COORD_BITS-1:0];
		r.origin_x = bx[COORD_BITS-1:0];
		r.origin_y = by[COORD_BITS-1:0];
		r.full     = full;
		r.last     = 1'b0;
		rect_batch.push_back(r);
	endtask

	// strip [a0,a1) on one axis, cut at the wrap edge
	task automatic add_strip(bit columns, int a0, int a1, int sz, int bx, int by);
		int e;
		e = (a1 > sz) ? sz : a1;
		if (columns) add_rect(a0, 0, e, sz, bx, by, 1'b0);
		else add_rect(0, a0, sz, e, bx, by, 1'b0);
		if (a1 > sz) begin
			if (columns) add_rect(0, 0, a1 - sz, sz, bx, by, 1'b0);
			else add_rect(0, 0, sz, a1 - sz, bx, by, 1'b0);
		end
	endtask

	task automatic scroll_level(logic [LVL_W-1:0] lvl, logic signed [ORIGIN_W-1:0] nx,
		logic signed [ORIGIN_W-1:0] ny);
		int  cnt, sz, l, dx, dy, bdx, bdy, spacing, ox, oy, newx, newy;
		bit  was_dirty;
		cnt = eff_count();
		sz  = eff_size();
		l   = int'(lvl);
		if (l >= cnt) return;
		was_dirty = level_dirty[l];
		dx = int'(nx) - int'(origin_x[l]);
		dy = int'(ny) - int'(origin_y[l]);
		if (!was_dirty && dx == 0 && dy == 0) return;
		origin_x[l]    = nx;
		origin_y[l]    = ny;
		level_dirty[l] = 1'b0;
		rect_batch.delete();
		if (was_dirty || (dx < 0 ? -dx : dx) >= sz || (dy < 0 ? -dy : dy) >= sz) begin
			wrap_x[l] = '0;
			wrap_y[l] = '0;
			add_rect(0, 0, sz, sz, 0, 0, 1'b1);
		end else begin
			spacing = 1 << (cnt - 1 - l);
			bdx  = dx / spacing;
			bdy  = dy / spacing;
			ox   = int'(wrap_x[l]) % sz;
			oy   = int'(wrap_y[l]) % sz;
			newx = wrap_to(ox + bdx, sz);
			newy = wrap_to(oy + bdy, sz);
			wrap_x[l] = newx[COORD_BITS-1:0];
			wrap_y[l] = newy[COORD_BITS-1:0];
			if (bdx > 0) add_strip(1'b1, ox, ox + bdx, sz, newx, newy);
			else if (bdx < 0) add_strip(1'b1, newx, newx - bdx, sz, newx, newy);
			if (bdy > 0) add_strip(1'b0, oy, oy + bdy, sz, newx, newy);
			else if (bdy < 0) add_strip(1'b0, newy, newy - bdy, sz, newx, newy);
		end
		if (rect_batch.size() > 0) rect_batch[rect_batch.size()-1].last = 1'b1;
		foreach (rect_batch[i]) rects_due.push_back(rect_batch[i]);
	endtask

	task automatic check_field(string name, logic [COORD_BITS-1:0] want,
		logic [COORD_BITS-1:0] got);
		if (want !== got) begin
			$error("%s expected %0d got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// request driver
	always @(posedge clk) begin : req_drive
		level_move_t next_move;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				scroll_level(req_ch.level_index, req_ch.new_origin_x, req_ch.new_origin_y);
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (moves_pending.size() > 0) begin
					next_move = moves_pending.pop_front();
					req_ch.valid        <= 1'b1;
					req_ch.level_index  <= next_move.lvl;
					req_ch.new_origin_x <= next_move.x;
					req_ch.new_origin_y <= next_move.y;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 8);
						if (sender_quiet) gap_left = 0;
						else if ($urandom_range(0, 3) == 0) gap_left = $urandom_range(5, 20);
						else gap_left = $urandom_range(0, 3);
					end
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// rect monitor
	always @(posedge clk) begin : rect_check
		dirty_rect_t want;
		if (!arst_n) begin
			rect_ch.ready <= 1'b0;
		end else begin
			if (rect_ch.valid && rect_ch.ready) begin
				if (rects_due.size() == 0) begin
					$error("rect received with none expected");
					mismatches++;
				end else begin
					want = rects_due.pop_front();
					check_field("rect_x_start", want.x_start, rect_ch.rect_x_start);
					check_field("rect_y_start", want.y_start, rect_ch.rect_y_start);
					check_field("rect_x_end", want.x_end, rect_ch.rect_x_end);
					check_field("rect_y_end", want.y_end, rect_ch.rect_y_end);
					check_field("block_origin_x", want.origin_x, rect_ch.block_origin_x);
					check_field("block_origin_y", want.origin_y, rect_ch.block_origin_y);
					check_field("full_update", COORD_BITS'(want.full),
						COORD_BITS'(rect_ch.full_update));
					check_field("last_rect", COORD_BITS'(want.last),
						COORD_BITS'(rect_ch.last_rect));
				end
			end
			ready_phase = (ready_phase + 1) % 16;
			rect_ch.ready <= no_stall | stall_pattern[ready_phase];
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rect_ch.valid && rect_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready) || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic queue_move(logic [LVL_W-1:0] lvl, logic signed [ORIGIN_W-1:0] x,
		logic signed [ORIGIN_W-1:0] y);
		level_move_t m;
		m.lvl = lvl;
		m.x   = x;
		m.y   = y;
		moves_pending.push_back(m);
		sent_x[lvl] = x;
		sent_y[lvl] = y;
	endtask

	task automatic queue_random_move();
		int cnt, sz, lvl, spacing, reach, roll, dx, dy;
		cnt     = eff_count();
		sz      = eff_size();
		lvl     = $urandom_range(0, cnt - 1);
		spacing = 1 << (cnt - 1 - lvl);
		reach   = (sz - 1) / spacing;
		roll    = $urandom_range(0, 99);
		dx      = 0;
		dy      = 0;
		if (roll < 8) begin
			queue_move(LVL_W'($urandom_range(0, 15)), ORIGIN_W'($urandom()),
				ORIGIN_W'($urandom()));
			return;
		end
		if (roll >= 14 && roll < 22) begin
			dx = sz + int'($urandom_range(0, sz));
			if ($urandom_range(0, 1)) dx = -dx;
			dy = int'($urandom_range(0, 2 * sz)) - sz;
			if ($urandom_range(0, 1)) begin
				roll = dx;
				dx   = dy;
				dy   = roll;
			end
		end else if (roll >= 22 && roll < 28) begin
			dx = int'($urandom_range(0, spacing - 1));
			dy = -int'($urandom_range(0, spacing - 1));
		end else if (roll >= 28) begin
			dx = spacing * (int'($urandom_range(0, 2 * reach)) - reach);
			dy = spacing * (int'($urandom_range(0, 2 * reach)) - reach);
			case ($urandom_range(0, 3))
				0: dx = 0;
				1: dy = 0;
				default: ;
			endcase
		end
		queue_move(LVL_W'(lvl), ORIGIN_W'(int'(sent_x[lvl]) + dx),
			ORIGIN_W'(int'(sent_y[lvl]) + dy));
	endtask

	task automatic settle();
		while (moves_pending.size() != 0 || req_ch.valid || rects_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			REG_LEVEL_SIZE:  level_size_reg = val[COORD_BITS-1:0];
			REG_LEVEL_COUNT: level_count_reg = val[CNT_W-1:0];
			default: ;
		endcase
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_levels(logic [CFG_DATA_W-1:0] sz, logic [CFG_DATA_W-1:0] cnt, bit calm);
		settle();
		write_reg(REG_LEVEL_SIZE, sz);
		write_reg(REG_LEVEL_COUNT, cnt);
		sender_quiet  = calm || ($urandom_range(0, 3) == 0);
		no_stall      = calm || ($urandom_range(0, 3) == 0);
		stall_pattern = 16'($urandom()) | 16'h1;
	endtask

	initial begin
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.level_index  = '0;
		req_ch.new_origin_x = '0;
		req_ch.new_origin_y = '0;
		rect_ch.ready       = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = REG_LEVEL_SIZE;
		cfg_ch.data         = '0;
		level_size_reg      = SIZE_RESET;
		level_count_reg     = COUNT_RESET;
		mismatches          = 0;
		burst_left          = 4;
		gap_left            = 0;
		idle_cycles         = 0;
		ready_phase         = 0;
		sender_quiet        = 1'b0;
		no_stall            = 1'b0;
		stall_pattern       = 16'($urandom()) | 16'h1;
		for (int i = 0; i < MAX_LEVELS; i++) begin
			origin_x[i]    = '0;
			origin_y[i]    = '0;
			wrap_x[i]      = '0;
			wrap_y[i]      = '0;
			level_dirty[i] = 1'b1;
			sent_x[i]      = '0;
			sent_y[i]      = '0;
		end

		// reset settings: size 255, 8 levels
		queue_move(7, 0, 0);
		queue_move(7, 0, 0);
		queue_move(7, 5, 0);
		queue_move(7, 5, -3);
		queue_move(7, 257, -6);
		queue_move(7, 247, 4);
		queue_move(7, 502, 4);
		queue_move(7, 756, 4);
		queue_move(7, 756, -250);
		queue_move(8, 1, 1);
		queue_move(15, 0, 0);
		queue_move(0, 0, 0);
		queue_move(0, 128, 0);
		queue_move(0, 192, 0);
		queue_move(0, 0, -128);
		queue_move(3, 24'sh7FFFFF, -24'sh800000);
		queue_move(3, -24'sh800000, 24'sh7FFFFF);
		queue_move(6, -2, -2);
		queue_move(6, 0, 2);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		set_levels(12'd4095, 12'd16, 1'b1);
		repeat (22) queue_random_move();
		set_levels(12'd3, 12'd1, 1'b0);
		repeat (12) queue_random_move();
		set_levels(12'd0, 12'd0, 1'b0);
		repeat (10) queue_random_move();
		set_levels(12'd100, 12'hFE4, 1'b0);
		repeat (15) queue_random_move();
		set_levels(12'd2000, 12'd31, 1'b0);
		repeat (15) queue_random_move();
		set_levels(CFG_DATA_W'($urandom_range(3, 4095)), CFG_DATA_W'($urandom_range(0, 31)),
			1'b0);
		repeat (15) queue_random_move();
		set_levels(12'd255, 12'd8, 1'b0);
		repeat (15) queue_random_move();

		settle();
		if (mismatches == 0 && rects_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
